// ===== design/assert_macros.svh =====
// Assertion macros used by the stencil top-level RTL.
// Clocked properties with a synchronous active-low reset as the disable term.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fps_pkg.sv =====
// Shared constants and types for the five-point stencil block.
// No dependencies; used by every module of the block.
package fps_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int GRID_COLS_W = 11;
  localparam int LIMIT_W     = 10;
  localparam int ROW_W       = 11;
  localparam int FRAC_BITS   = 16;
  localparam int RECIP_K_W   = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int MIN_COLS    = 3;

  // round(65536 / 5.5)
  localparam logic [RECIP_K_W-1:0] RECIP_K = 14'd11916;

  localparam logic [ROW_W-1:0]       ROW_MAX       = '1;
  localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST = 11'd1024;
  localparam logic [LIMIT_W-1:0]     LIMIT_RST     = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 2'd0,
    REG_ROW_LIMIT = 2'd1,
    REG_COL_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               valid;
    logic [LIMIT_W-1:0] row;
    logic [LIMIT_W-1:0] col;
  } fps_meta_t;

endpackage

// ===== design/fps_line_buf.sv =====
// Line buffer: one write port, two registered read ports, read-before-write.
// Depends on fps_pkg for default sizes.
module fps_line_buf import fps_pkg::*; #(
  parameter int DEPTH = MAX_COLS_DEF,
  parameter int WIDTH = SAMPLE_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== design/fps_arith.sv =====
// Stencil arithmetic chain: neighbor sum, scale by 1/5.5, round and saturate.
// Sum and split-product register stages advance together on adv. Depends on fps_pkg.
module fps_arith import fps_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  fps_meta_t                     in_meta,
  input  logic signed [SAMPLE_BITS-1:0] up,
  input  logic signed [SAMPLE_BITS-1:0] down,
  input  logic signed [SAMPLE_BITS-1:0] left,
  input  logic signed [SAMPLE_BITS-1:0] right,
  output fps_meta_t                     out_meta,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int SW  = (SAMPLE_BITS > FRAC_BITS) ? SAMPLE_BITS + 2 : FRAC_BITS + 2;
  localparam int HW  = SW - FRAC_BITS;
  localparam int PHW = HW + RECIP_K_W + 1;
  localparam int PLW = FRAC_BITS + RECIP_K_W;
  localparam int FQW = PLW - FRAC_BITS + 1;
  localparam logic signed [RECIP_K_W:0] K_S = {1'b0, RECIP_K};
  localparam logic [PLW:0] RND = (PLW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [SW-1:0]  sum_nxt, sum_r;
  logic signed [PHW-1:0] ph_nxt, ph_r;
  logic [PLW-1:0]        pl_nxt, pl_r;
  fps_meta_t             m2_r, m3_r;
  logic [PLW:0]          pl_rnd;
  logic [FQW-1:0]        frac_q;
  logic signed [SW-1:0]  q;
  logic [SW-SAMPLE_BITS:0] q_top;

  assign sum_nxt = SW'(up) + SW'(down) + SW'(left) + SW'(right);

  // S*K split at the binary point: hi part signed, lo part 16 unsigned bits
  assign ph_nxt = $signed(sum_r[SW-1:FRAC_BITS]) * K_S;
  assign pl_nxt = sum_r[FRAC_BITS-1:0] * RECIP_K;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_r.valid <= 1'b0;
      m3_r.valid <= 1'b0;
    end else if (adv) begin
      m2_r    <= in_meta;
      m3_r    <= m2_r;
      sum_r   <= sum_nxt;
      ph_r    <= ph_nxt;
      pl_r    <= pl_nxt;
    end
  end

  always_comb begin
    pl_rnd = {1'b0, pl_r} + RND;
    frac_q = pl_rnd[PLW:FRAC_BITS];
    q      = SW'(ph_r) + SW'($signed({1'b0, frac_q}));
    q_top  = q[SW-1:SAMPLE_BITS-1];
    if ((&q_top) || !(|q_top)) begin
      result = q[SAMPLE_BITS-1:0];
    end else if (q[SW-1]) begin
      result = SAT_MIN;
    end else begin
      result = SAT_MAX;
    end
  end

  assign out_meta = m3_r;

endmodule

// ===== design/five_point_stencil_2d.sv =====
// Five-point stencil (four neighbors, no center) over a raster-order grid.
// Uses fps_pkg, fps_line_buf, fps_arith and assert_macros.svh.
//
// Input channel (in_valid / in_stall): one grid sample per beat, raster order,
// in_frame_start marks row 0 column 0. A beat at row r, column j yields the
// result for center (r-1, j) when that cell is interior and inside the
// row/column limits; border cells yield no output beat.
// Output channel (out_valid / out_stall): result in Q16.16 plus the center's
// row and column, in input order.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
// grid_cols, row_limit and col_limit only while the block is idle.
// Throughput: one sample per cycle while in_stall is low. Both neighbor rows
// come from two line buffers, the previous-row buffer read at columns j and
// j+1 in the same cycle. Results pass the window, arithmetic and output registers.
// When out_stall holds a result, one more result lands in a skid register and
// in_stall is high while it is full, freezing the pipeline until it drains.
// Reset clears the counters, config (1024 cols, limits 1023) and all valids;
// line buffer contents are not cleared and need no clearing pass.
module five_point_stencil_2d import fps_pkg::*; #(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_result,
  output logic [LIMIT_W-1:0]            out_center_row,
  output logic [LIMIT_W-1:0]            out_center_col,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int CW0    = $clog2(MAX_COLS + 1);
  localparam int CMPW   = (CW0 > GRID_COLS_W) ? CW0 : GRID_COLS_W;

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] v);
    return (v == ROW_MAX) ? v : v + 1'b1;
  endfunction

  logic [GRID_COLS_W-1:0] grid_cols_r;
  logic [LIMIT_W-1:0]     row_limit_r, col_limit_r;
  logic [ADDR_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;

  logic                   accept, adv;
  logic [CMPW-1:0]        gc, cols, c0, jx, jn;
  logic [ROW_W-1:0]       r0, r, r_m1;
  logic [ADDR_W-1:0]      j;
  logic                   emit;

  logic [SAMPLE_BITS-1:0] center_rd, right_rd, up_rd;
  logic                   s1_valid_r, s1_emit_r, fwd_hit_r;
  logic [ADDR_W-1:0]      s1_j_r;
  logic [LIMIT_W-1:0]     s1_row_r, s1_col_r;
  logic [SAMPLE_BITS-1:0] s1_x_r, fwd_data_r, last_center_r, up_val;

  fps_meta_t              s1_meta, a_meta;
  logic signed [SAMPLE_BITS-1:0] a_result;
  logic                   push;

  logic                   out_valid_r, skid_full_r;
  logic [SAMPLE_BITS-1:0] out_result_r, skid_result_r;
  logic [LIMIT_W-1:0]     out_row_r, out_col_r, skid_row_r, skid_col_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_COLS_RST;
      row_limit_r <= LIMIT_RST;
      col_limit_r <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_COLS: grid_cols_r <= cfg_data;
        REG_ROW_LIMIT: row_limit_r <= cfg_data[LIMIT_W-1:0];
        REG_COL_LIMIT: col_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- raster position ----------------
  assign adv      = !skid_full_r;
  assign in_stall = skid_full_r;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    gc = CMPW'(grid_cols_r);
    if (gc < CMPW'(MIN_COLS)) begin
      cols = CMPW'(MIN_COLS);
    end else if (gc > CMPW'(MAX_COLS)) begin
      cols = CMPW'(MAX_COLS);
    end else begin
      cols = gc;
    end

    c0 = in_frame_start ? '0 : CMPW'(col_r);
    r0 = in_frame_start ? '0 : row_r;

    // row cut short when grid_cols shrank below the current column
    if (c0 >= cols) begin
      jx = '0;
      r  = row_inc(r0);
    end else begin
      jx = c0;
      r  = r0;
    end

    j    = jx[ADDR_W-1:0];
    jn   = jx + 1'b1;
    r_m1 = r - 1'b1;

    emit = (r >= ROW_W'(2)) && (r_m1 < ROW_W'(row_limit_r)) && (jx != '0)
           && (jx < CMPW'(col_limit_r)) && (jn < cols);

    if (jn >= cols) begin
      col_nxt = '0;
      row_nxt = row_inc(r);
    end else begin
      col_nxt = jn[ADDR_W-1:0];
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- line buffers ----------------
  fps_line_buf #(.DEPTH(MAX_COLS), .WIDTH(SAMPLE_BITS)) u_prev_row (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (j),
    .wr_data   (in_sample),
    .rd_en     (accept),
    .rd_addr_a (j),
    .rd_addr_b (jn[ADDR_W-1:0]),
    .rd_data_a (center_rd),
    .rd_data_b (right_rd)
  );

  // older row takes the previous row's old value once the window stage advances
  fps_line_buf #(.DEPTH(MAX_COLS), .WIDTH(SAMPLE_BITS)) u_prev2_row (
    .clk       (clk),
    .wr_en     (s1_valid_r && adv),
    .wr_addr   (s1_j_r),
    .wr_data   (center_rd),
    .rd_en     (accept),
    .rd_addr_a (j),
    .rd_addr_b (j),
    .rd_data_a (up_rd),
    .rd_data_b ()
  );

  // ---------------- window stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r  <= emit;
      s1_j_r     <= j;
      s1_row_r   <= r_m1[LIMIT_W-1:0];
      s1_col_r   <= jx[LIMIT_W-1:0];
      s1_x_r     <= in_sample;
      // pending older-row write to the same column is not in the RAM yet
      fwd_hit_r  <= s1_valid_r && (s1_j_r == j);
      fwd_data_r <= center_rd;
    end
    // left neighbor = previous beat's center, already shifted into the older row
    if (s1_valid_r && adv) begin
      last_center_r <= center_rd;
    end
  end

  assign up_val        = fwd_hit_r ? fwd_data_r : up_rd;
  assign s1_meta.valid = s1_valid_r && s1_emit_r;
  assign s1_meta.row   = s1_row_r;
  assign s1_meta.col   = s1_col_r;

  fps_arith #(.SAMPLE_BITS(SAMPLE_BITS)) u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_meta  (s1_meta),
    .up       (up_val),
    .down     (s1_x_r),
    .left     (last_center_r),
    .right    (right_rd),
    .out_meta (a_meta),
    .result   (a_result)
  );

  // ---------------- output register and skid ----------------
  assign push = adv && a_meta.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= skid_full_r || push;
      skid_full_r <= 1'b0;
    end else if (push) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_full_r) begin
        out_result_r <= skid_result_r;
        out_row_r    <= skid_row_r;
        out_col_r    <= skid_col_r;
      end else if (push) begin
        out_result_r <= a_result;
        out_row_r    <= a_meta.row;
        out_col_r    <= a_meta.col;
      end
    end else if (push) begin
      skid_result_r <= a_result;
      skid_row_r    <= a_meta.row;
      skid_col_r    <= a_meta.col;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result     = out_result_r;
  assign out_center_row = out_row_r;
  assign out_center_col = out_col_r;

  // ---------------- checks ----------------
`include "assert_macros.svh"

  `ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_full_r, out_valid_r, "skid full, output empty")
  `ASSERT_NXT(a_skid_drains, clk, rst_n, skid_full_r && !out_stall, !skid_full_r, "skid not drained")
  `ASSERT_IMP(a_interior_only, clk, rst_n, out_valid_r, (out_row_r != '0) && (out_col_r != '0), "border cell emitted")
  `ASSERT_NXT(a_frame_restart, clk, rst_n, accept && in_frame_start, (col_r == ADDR_W'(1)) && (row_r == '0), "frame start did not restart raster")

endmodule

// ===== tb/tb_five_point_stencil_2d.sv =====
// Self-checking testbench for five_point_stencil_2d: streams raster grids with
// random idles and back-pressure, and checks each beat against an in-bench model.
// Depends on fps_pkg and the five_point_stencil_2d RTL only.
module tb_five_point_stencil_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import fps_pkg::*;

  localparam longint RECIP_5P5   = 11916;  // round(65536 / 5.5)
  localparam longint SAT_MAX     = 64'sd2147483647;
  localparam longint SAT_MIN     = -64'sd2147483648;
  localparam int     ROW_SAT     = 2047;
  localparam int     LINE_DEPTH  = 1024;
  localparam int     RANDOM_ITEMS = 1050;
  localparam int     CYCLE_LIMIT = 2500000;

  typedef struct packed {
    logic signed [31:0]  value;
    logic [LIMIT_W-1:0]  row;
    logic [LIMIT_W-1:0]  col;
  } cell_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic signed [31:0]    in_sample;
  logic                  in_frame_start;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [31:0]    out_result;
  logic [LIMIT_W-1:0]    out_center_row;
  logic [LIMIT_W-1:0]    out_center_col;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // grid state mirrored from the block
  logic signed [31:0] line_up1 [LINE_DEPTH];
  logic signed [31:0] line_up2 [LINE_DEPTH];
  int row_idx = 0;
  int col_idx = 0;
  int cols_reg = 1024;
  int row_limit_reg = 1023;
  int col_limit_reg = 1023;

  cell_result_t pending_cells [$];
  int  error_count = 0;
  int  samples_sent = 0;
  int  cycle_count = 0;
  int  hold_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stall_en = 1'b1;

  five_point_stencil_2d dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .out_center_row(out_center_row),
    .out_center_col(out_center_col),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("five_point_stencil_2d test failed");
      $finish;
    end
  end

  function automatic int eff_width(input int v);
    if (v < 3) return 3;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return v;
  endfunction

  function automatic void wrap_row(input int width);
    if (col_idx >= width) begin
      col_idx = 0;
      if (row_idx < ROW_SAT) row_idx++;
    end
  endfunction

  // One accepted sample: emit the center one row up, then shift the line buffers.
  function automatic void jacobi_step(input logic signed [31:0] s, input logic fs);
    int width, r, j;
    longint acc, q;
    cell_result_t res;
    width = eff_width(cols_reg);
    if (fs) begin
      row_idx = 0;
      col_idx = 0;
    end
    wrap_row(width);
    r = row_idx;
    j = col_idx;
    if (r >= 2 && r - 1 < row_limit_reg && j >= 1 && j < col_limit_reg
        && j + 1 < width) begin
      acc = longint'(line_up2[j]) + longint'(line_up2[j-1]) + longint'(line_up1[j+1])
            + longint'(s);
      q = (acc * RECIP_5P5 + 64'sd32768) >>> 16;
      if (q > SAT_MAX) q = SAT_MAX;
      if (q < SAT_MIN) q = SAT_MIN;
      res.value = q[31:0];
      res.row = LIMIT_W'(r - 1);
      res.col = LIMIT_W'(j);
      pending_cells.push_back(res);
    end
    line_up2[j] = line_up1[j];
    line_up1[j] = s;
    col_idx = j + 1;
    wrap_row(width);
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int small_val;
    small_val = int'($urandom_range(0, 2097152)) - 1048576;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: begin
        case ($urandom_range(0, 6))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return -32'sd1;
          3: return 32'sd1;
          4: return 32'sh00010000;
          5: return 32'shFFFF0000;
          default: return 32'sd0;
        endcase
      end
      default: return small_val;
    endcase
  endfunction

  // Output side: random stall bursts, plus a long hold-off when requested.
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (stall_en && $urandom_range(0, 99) < 20) begin
        burst = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                             : $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected beat result=%0d row=%0d col=%0d", $time,
                 out_result, out_center_row, out_center_col);
        error_count++;
      end else begin
        want = pending_cells.pop_front();
        if (out_result !== want.value || out_center_row !== want.row ||
            out_center_col !== want.col) begin
          $display("%0t: mismatch expected result=%0d row=%0d col=%0d,",
                   $time, want.value, want.row, want.col,
                   " got %0d row=%0d col=%0d",
                   out_result, out_center_row, out_center_col);
          error_count++;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [31:0] s, input logic fs);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    jacobi_step(s, fs);
    samples_sent++;
  endtask

  task automatic send_frame(input int rows, input int cols, input bit use_fill,
                            input logic signed [31:0] fill);
    for (int i = 0; i < rows * cols; i++)
      send_sample(use_fill ? fill : pick_sample(), i == 0);
  endtask

  // Idle the input and wait for every outstanding beat, plus pipeline settle time.
  task automatic drain(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GRID_COLS: cols_reg = value[10:0];
      REG_ROW_LIMIT: row_limit_reg = value[9:0];
      REG_COL_LIMIT: col_limit_reg = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input int cols, input int row_lim, input int col_lim);
    drain(8);
    write_reg(REG_GRID_COLS, cols);
    write_reg(REG_ROW_LIMIT, row_lim);
    write_reg(REG_COL_LIMIT, col_lim);
  endtask

  // Counters start at zero after reset, so no frame_start is needed.
  // Rows 0-2 at 2048 make the neighbor sum land exactly on a rounding tie.
  task automatic test_start_without_frame_start();
    set_grid(5, 1023, 1023);
    for (int i = 0; i < 15; i++) send_sample(32'sd2048, 1'b0);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b0);
  endtask

  task automatic test_width_clamp_and_limits();
    set_grid(0, 2, 2);
    send_frame(4, 3, 1'b1, -32'sd2048);       // negative tie
    set_grid(1, 1023, 1023);
    send_frame(3, 3, 1'b1, 32'sh7FFFFFFF);
    set_grid(2, 2047, 2047);                  // limits masked to 10 bits
    send_frame(3, 3, 1'b1, 32'sh80000000);
    set_grid(3, 1, 1023);
    send_frame(3, 3, 1'b0, 0);
    set_grid(3, 0, 1023);
    send_frame(3, 3, 1'b0, 0);
    set_grid(3, 1023, 1);
    send_frame(3, 3, 1'b0, 0);
    set_grid(3, 1023, 0);
    send_frame(3, 3, 1'b0, 0);
  endtask

  // Shrinking the row mid-row ends the current row before the next sample.
  task automatic test_resize_mid_row();
    set_grid(8, 1023, 1023);
    for (int i = 0; i < 29; i++) send_sample(pick_sample(), i == 0);
    drain(8);
    write_reg(REG_GRID_COLS, 4);
    for (int i = 0; i < 8; i++) send_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_output_backpressure();
    set_grid(6, 1023, 1023);
    gaps_on = 1'b0;
    stall_en = 1'b0;
    hold_cycles = 200;
    send_frame(8, 6, 1'b0, 0);
    send_frame(5, 6, 1'b0, 0);
    gaps_on = 1'b1;
    stall_en = 1'b1;
  endtask

  task automatic test_random_frames();
    int start_count, cols, width, rows, row_lim, col_lim, n;
    start_count = samples_sent;
    while (samples_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: cols = $urandom_range(0, 3);
        8: cols = $urandom_range(13, 40);
        9: cols = $urandom_range(41, 80);
        default: cols = $urandom_range(3, 12);
      endcase
      width = eff_width(cols);
      case ($urandom_range(0, 7))
        0: row_lim = $urandom_range(0, 1);
        1, 2: row_lim = $urandom_range(2, 6);
        3: row_lim = $urandom_range(7, 1023);
        default: row_lim = 1023;
      endcase
      case ($urandom_range(0, 7))
        0: col_lim = $urandom_range(0, 1);
        1, 2: col_lim = $urandom_range(2, width);
        3: col_lim = $urandom_range(2, 1023);
        default: col_lim = 1023;
      endcase
      set_grid(cols, row_lim, col_lim);
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < $urandom_range(1, 3); k++) begin
        rows = (width > 20) ? $urandom_range(3, 5) : $urandom_range(3, 10);
        // every phase opens with a clean frame so the line buffers match the width
        if (k == 0 || $urandom_range(0, 9) < 7) begin
          send_frame(rows, width, 1'b0, 0);
        end else if ($urandom_range(0, 1) == 0) begin
          n = $urandom_range(1, rows * width - 1);
          for (int i = 0; i < n; i++) send_sample(pick_sample(), i == 0);
        end else begin
          n = $urandom_range(5, 3 * width + 5);
          for (int i = 0; i < n; i++)
            send_sample(pick_sample(), $urandom_range(0, 15) == 0);
        end
      end
    end
    gaps_on = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_frame_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_COLS;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_start_without_frame_start();
    test_width_clamp_and_limits();
    test_resize_mid_row();
    test_output_backpressure();
    test_random_frames();
    drain(10);

    if (error_count == 0) begin
      $display("five_point_stencil_2d test passed");
    end else begin
      $display("five_point_stencil_2d test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fps_pkg.sv
design/fps_line_buf.sv
design/fps_arith.sv
design/five_point_stencil_2d.sv
tb/tb_five_point_stencil_2d.sv
